// File: rtl/fg_bg_tile_sprite_expander_macros.svh
// Assertion macros for the tile sprite expander.
`ifndef FG_BG_TILE_SPRITE_EXPANDER_MACROS_SVH
`define FG_BG_TILE_SPRITE_EXPANDER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FBTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbte same-cycle check failed");

// Next-cycle implication.
`define FBTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbte next-cycle check failed");

`endif

// File: rtl/fbte_pkg.sv
// Shared types, register codes and colour table of the tile sprite expander.
package fbte_pkg;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_WIDTH_TILES  = 3'd2,
    CFG_HEIGHT_TILES = 3'd3,
    CFG_ALPHA_EN     = 3'd4,
    CFG_ALPHA_LIMIT  = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ORIGIN_W = 11;
  localparam int unsigned SIZE_W = 9;

  // Tile held between front and back; base position already resolved.
  typedef struct packed {
    logic [15:0]        mask;
    logic [3:0]         fg_idx;
    logic [3:0]         bg_idx;
    logic [3:0]         alpha_nib;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
  } tile_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic active;
    logic pix_load;
  } bk_status_t;

  function automatic logic [23:0] colour_lookup(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h002B36;
      4'd1:    c = 24'h073642;
      4'd2:    c = 24'h586E75;
      4'd3:    c = 24'h657B83;
      4'd4:    c = 24'h839496;
      4'd5:    c = 24'h93A1A1;
      4'd6:    c = 24'hEEE8D5;
      4'd7:    c = 24'hFDF6E3;
      4'd8:    c = 24'hB58900;
      4'd9:    c = 24'hCB4B16;
      4'd10:   c = 24'hDC322F;
      4'd11:   c = 24'hD33682;
      4'd12:   c = 24'h6C71C4;
      4'd13:   c = 24'h268BD2;
      4'd14:   c = 24'h2AA198;
      4'd15:   c = 24'h859900;
      default: c = 24'h002B36;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/fbte_front.sv
// Front end: takes tile words, masks alpha, tracks the tile position, drops empty tiles.
module fbte_front #(
  parameter int unsigned MAX_TILES_WIDE = 256,
  parameter int unsigned MAX_TILES_HIGH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_tile_word,
  input  logic [fbte_pkg::ORIGIN_W-1:0]  origin_x,
  input  logic [fbte_pkg::ORIGIN_W-1:0]  origin_y,
  input  logic [fbte_pkg::SIZE_W-1:0]    width_tiles,
  input  logic [fbte_pkg::SIZE_W-1:0]    height_tiles,
  input  logic                           alpha_mode_enable,
  input  logic [3:0]                     alpha_limit,
  input  fbte_pkg::q_status_t            q_stat,
  output logic                           push,
  output fbte_pkg::tile_entry_t          push_entry
);
  import fbte_pkg::*;

  localparam int unsigned COL_W = (MAX_TILES_WIDE > 1) ? $clog2(MAX_TILES_WIDE) : 1;
  localparam int unsigned ROW_W = (MAX_TILES_HIGH > 1) ? $clog2(MAX_TILES_HIGH) : 1;
  localparam logic [SIZE_W-1:0] MaxW = SIZE_W'(MAX_TILES_WIDE);
  localparam logic [SIZE_W-1:0] MaxH = SIZE_W'(MAX_TILES_HIGH);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SIZE_W-1:0] w_eff, h_eff, col_p1, row_p1;
  logic [3:0]        nib;
  logic              accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign nib      = alpha_mode_enable ? (in_tile_word[31:28] & alpha_limit)
                                      : in_tile_word[31:28];

  always_comb begin
    w_eff = (width_tiles == '0) ? SIZE_W'(1)
          : ((width_tiles > MaxW) ? MaxW : width_tiles);
    h_eff = (height_tiles == '0) ? SIZE_W'(1)
          : ((height_tiles > MaxH) ? MaxH : height_tiles);
    col_p1 = SIZE_W'(col_r) + SIZE_W'(1);
    row_p1 = SIZE_W'(row_r) + SIZE_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_p1 >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= h_eff) ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign push = accept && (nib != 4'd0);

  always_comb begin
    push_entry.mask      = in_tile_word[15:0];
    push_entry.fg_idx    = in_tile_word[19:16];
    push_entry.bg_idx    = in_tile_word[23:20];
    push_entry.alpha_nib = nib;
    push_entry.base_x    = COORD_W'(origin_x) + COORD_W'({col_r, 2'b00});
    push_entry.base_y    = COORD_W'(origin_y) + COORD_W'({row_r, 2'b00});
  end

endmodule

// File: rtl/fbte_queue.sv
// Two-entry tile queue between front and back.
module fbte_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fbte_pkg::tile_entry_t push_entry,
  input  logic                  pop,
  output fbte_pkg::tile_entry_t pop_entry,
  output fbte_pkg::q_status_t   q_stat
);
  import fbte_pkg::*;

  tile_entry_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/fbte_back.sv
// Back end: expands one queued tile into sixteen pixels into a registered output.
module fbte_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fbte_pkg::q_status_t           q_stat,
  input  fbte_pkg::tile_entry_t         pop_entry,
  output logic                          pop,
  output fbte_pkg::bk_status_t          bk_stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbte_pkg::COORD_W-1:0]  out_pixel_x,
  output logic [fbte_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha,
  output logic                          out_last_pixel
);
  import fbte_pkg::*;

  tile_entry_t        tile_r, tile_nxt;
  logic               active_r, active_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [COORD_W-1:0] px_r, py_r;
  logic [23:0]        rgb_r;
  logic [7:0]         alpha_r;
  logic               last_r;
  logic               pix_load, bit_set;
  logic [23:0]        rgb_sel;
  logic [1:0]         a2;

  assign pix_load = active_r && (!ovalid_r || !out_stall);
  assign pop = q_stat.empty ? 1'b0
             : (!active_r || (pix_load && idx_r == 4'd15));

  assign bk_stat.active   = active_r;
  assign bk_stat.pix_load = pix_load;

  always_comb begin
    tile_nxt   = tile_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (pix_load) begin
      idx_nxt = idx_r + 4'd1;
      if (idx_r == 4'd15) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      tile_nxt   = pop_entry;
      active_nxt = 1'b1;
      idx_nxt    = 4'd0;
    end
    if (pix_load) begin
      ovalid_nxt = 1'b1;
    end else if (!out_stall) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_comb begin
    bit_set = tile_r.mask[idx_r];
    rgb_sel = bit_set ? colour_lookup(tile_r.fg_idx) : colour_lookup(tile_r.bg_idx);
    // 2-bit alpha times 0x55 is the pair repeated four times
    a2 = bit_set ? tile_r.alpha_nib[1:0] : tile_r.alpha_nib[3:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= 4'd0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tile_r <= tile_nxt;
    if (pix_load) begin
      px_r    <= tile_r.base_x + COORD_W'(idx_r[1:0]);
      py_r    <= tile_r.base_y + COORD_W'(idx_r[3:2]);
      rgb_r   <= rgb_sel;
      alpha_r <= {4{a2}};
      last_r  <= (idx_r == 4'd15);
    end
  end

  assign out_valid      = ovalid_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_red        = rgb_r[23:16];
  assign out_green      = rgb_r[15:8];
  assign out_blue       = rgb_r[7:0];
  assign out_alpha      = alpha_r;
  assign out_last_pixel = last_r;

endmodule

// File: rtl/fg_bg_tile_sprite_expander.sv
// Top level of the two-colour 4x4 tile sprite expander.
// Each accepted tile word whose (optionally limited) alpha nibble is nonzero produces sixteen
// pixel beats in raster order inside the 4x4 cell, one beat per cycle from the back-end
// expander while out_stall is low. A tile with a zero alpha nibble is accepted, emits
// nothing and only advances the tile position. A two-tile queue sits between the front end
// and the expander, so the input keeps taking words while pixels drain until the queue is
// full; a tile passes through its queue slot and the back end's tile register before the
// output registers show its first pixel. The configuration port is always ready; write
// registers only while the block is idle.
module fg_bg_tile_sprite_expander #(
  parameter int unsigned MAX_TILES_WIDE = 256,
  parameter int unsigned MAX_TILES_HIGH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     in_tile_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fbte_pkg::COORD_W-1:0]    out_pixel_x,
  output logic [fbte_pkg::COORD_W-1:0]    out_pixel_y,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic                            out_last_pixel,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbte_pkg::*;

  `include "fg_bg_tile_sprite_expander_macros.svh"

  logic [ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic [SIZE_W-1:0]   width_tiles_r, height_tiles_r;
  logic                alpha_en_r;
  logic [3:0]          alpha_limit_r;

  logic        push, pop;
  tile_entry_t push_entry, pop_entry;
  q_status_t   q_stat;
  bk_status_t  bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      width_tiles_r  <= SIZE_W'(1);
      height_tiles_r <= SIZE_W'(1);
      alpha_en_r     <= 1'b0;
      alpha_limit_r  <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data[ORIGIN_W-1:0];
        CFG_WIDTH_TILES:  width_tiles_r  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT_TILES: height_tiles_r <= cfg_data[SIZE_W-1:0];
        CFG_ALPHA_EN:     alpha_en_r     <= cfg_data[0];
        CFG_ALPHA_LIMIT:  alpha_limit_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  fbte_front #(
    .MAX_TILES_WIDE (MAX_TILES_WIDE),
    .MAX_TILES_HIGH (MAX_TILES_HIGH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tile_word      (in_tile_word),
    .origin_x          (origin_x_r),
    .origin_y          (origin_y_r),
    .width_tiles       (width_tiles_r),
    .height_tiles      (height_tiles_r),
    .alpha_mode_enable (alpha_en_r),
    .alpha_limit       (alpha_limit_r),
    .q_stat            (q_stat),
    .push              (push),
    .push_entry        (push_entry)
  );

  fbte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  fbte_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .bk_stat        (bk_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_last_pixel (out_last_pixel)
  );

  `FBTE_ASSERT_NOW(a_q_not_full_and_empty, 1'b1, !(q_stat.full && q_stat.empty))
  `FBTE_ASSERT_NEXT(a_pix_load_shows, bk_stat.pix_load, out_valid)
  `FBTE_ASSERT_NOW(a_pop_only_when_idle_slot, pop, !q_stat.empty)
  `FBTE_ASSERT_NOW(a_pix_load_needs_tile, bk_stat.pix_load, bk_stat.active)

endmodule

// File: test/fg_bg_tile_sprite_expander_tb.sv
// Self-checking testbench for the 4x4 two-color tile sprite expander.
`timescale 1ns / 100ps

package fbte_tb_pkg;
  import fbte_pkg::*;

  localparam int unsigned MAX_CELLS = 256;

  localparam logic [23:0] PALETTE [16] = '{
    24'h002B36, 24'h073642, 24'h586E75, 24'h657B83,
    24'h839496, 24'h93A1A1, 24'hEEE8D5, 24'hFDF6E3,
    24'hB58900, 24'hCB4B16, 24'hDC322F, 24'hD33682,
    24'h6C71C4, 24'h268BD2, 24'h2AA198, 24'h859900
  };

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               last_pixel;
  } pixel_t;

  // Tracks sprite position and register state; turns each tile into its pixel beats.
  class sprite_pixel_model;
    logic [ORIGIN_W-1:0] org_x, org_y;
    logic [SIZE_W-1:0]   wid, hgt;
    logic                alpha_en;
    logic [3:0]          alpha_lim;
    logic [7:0]          col, row;
    pixel_t              pending[$];
    int                  errors, tiles_seen, tiles_blank, pixels_seen;

    function new();
      org_x = '0;
      org_y = '0;
      wid = 9'd1;
      hgt = 9'd1;
      alpha_en = 1'b0;
      alpha_lim = 4'hF;
      col = '0;
      row = '0;
      errors = 0;
      tiles_seen = 0;
      tiles_blank = 0;
      pixels_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ORIGIN_X:     org_x = data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:     org_y = data[ORIGIN_W-1:0];
        CFG_WIDTH_TILES:  wid = data[SIZE_W-1:0];
        CFG_HEIGHT_TILES: hgt = data[SIZE_W-1:0];
        CFG_ALPHA_EN:     alpha_en = data[0];
        CFG_ALPHA_LIMIT:  alpha_lim = data[3:0];
        default: ;
      endcase
    endfunction

    // zero acts as one cell, anything past the maximum saturates
    function int unsigned cells(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_CELLS) return MAX_CELLS;
      return v;
    endfunction

    function void expand_tile(logic [31:0] word);
      logic [3:0]         nib;
      logic [1:0]         a_fg, a_bg;
      logic [23:0]        c_fg, c_bg, c;
      logic [COORD_W-1:0] bx, by;
      pixel_t             p;
      int unsigned        nc, nr;
      int                 i;
      nib = word[31:28];
      if (alpha_en) nib = nib & alpha_lim;
      tiles_seen++;
      if (nib == 4'h0) begin
        tiles_blank++;
      end else begin
        a_fg = nib[1:0];
        a_bg = nib[3:2];
        c_fg = PALETTE[word[19:16]];
        c_bg = PALETTE[word[23:20]];
        bx = {1'b0, org_x} + {2'b00, col, 2'b00};
        by = {1'b0, org_y} + {2'b00, row, 2'b00};
        for (i = 0; i < 16; i++) begin
          c = word[i] ? c_fg : c_bg;
          p.pixel_x = bx + COORD_W'(i & 3);
          p.pixel_y = by + COORD_W'(i >> 2);
          p.red = c[23:16];
          p.green = c[15:8];
          p.blue = c[7:0];
          p.alpha = 8'(word[i] ? a_fg : a_bg) * 8'h55;
          p.last_pixel = (i == 15);
          pending.push_back(p);
        end
      end
      // position moves on every tile, drawn or blank
      nc = col + 1;
      if (nc >= cells(wid)) begin
        nc = 0;
        nr = row + 1;
        if (nr >= cells(hgt)) nr = 0;
        row = nr[7:0];
      end
      col = nc[7:0];
    endfunction

    function void cmp_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        $error("pixel beat with nothing expected: x=%0d y=%0d", got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = pending.pop_front();
      pixels_seen++;
      cmp_field("pixel_x", want.pixel_x, got.pixel_x);
      cmp_field("pixel_y", want.pixel_y, got.pixel_y);
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("alpha", want.alpha, got.alpha);
      cmp_field("last_pixel", want.last_pixel, got.last_pixel);
    endfunction
  endclass

endpackage

module fg_bg_tile_sprite_expander_tb;
  import fbte_pkg::*;
  import fbte_tb_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_PHASES   = 6;
  localparam int TILES_PER_PHASE = 34;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [31:0] TILES_DEFAULT [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000, 32'hE0F0_5A5A,
    32'h6B8E_A5A5, 32'h2700_FFFF, 32'h9C12_3456, 32'h0FFF_FFFF
  };
  // alpha limit 0xA: nibbles 5 and 1 mask down to blank
  localparam logic [31:0] TILES_LIMITED [9] = '{
    32'hF555_0F0F, 32'h5FFF_FFFF, 32'hA123_C3C3, 32'h8765_8001, 32'h2ABC_0000,
    32'h3DEF_FFFF, 32'h1000_1111, 32'hB4A1_7777, 32'hE3C2_EEEE
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_tile_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_pixel_x;
  logic [COORD_W-1:0]   out_pixel_y;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic [7:0]           out_alpha;
  logic                 out_last_pixel;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic tx_gaps, rx_stalls, hold_req;
  int   settings_used;
  sprite_pixel_model model;

  fg_bg_tile_sprite_expander dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tile_word   (in_tile_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // handshakes seen at the rising edge feed the model
  always @(posedge clk) begin : monitor
    pixel_t got;
    if (rst_n && in_valid && !in_stall) model.expand_tile(in_tile_word);
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_x, out_pixel_y, out_red, out_green, out_blue, out_alpha,
              out_last_pixel};
      model.check_pixel(got);
    end
    if (rst_n && cfg_valid && cfg_ready) model.write_reg(cfg_index, cfg_data);
  end

  // pixel receiver: random stall bursts, plus one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // all driving tasks are entered and left at a falling edge
  task automatic send_tile(input logic [31:0] word);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      in_tile_word = $urandom();
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_tile_word = word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [10:0] ox, input logic [10:0] oy, input logic [10:0] w,
                           input logic [10:0] h, input logic en, input logic [3:0] lim);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_WIDTH_TILES, w);
    write_reg(CFG_HEIGHT_TILES, h);
    write_reg(CFG_ALPHA_EN, 11'(en));
    write_reg(CFG_ALPHA_LIMIT, 11'(lim));
    settings_used++;
  endtask

  // blank tiles leave nothing to wait for, so the wait is padded by DRAIN_CYCLES
  task automatic wait_drained();
    in_valid = 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [10:0] pick_origin();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'h7FF;
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [10:0] pick_cells();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'd256;
    if (r == 2) return 11'($urandom_range(257, 511));
    return 11'($urandom_range(1, 6));
  endfunction

  initial begin : stimulus
    logic [31:0] word;
    logic [10:0] w, h;
    logic        en;
    logic [3:0]  lim;
    int          ph, n, r;
    model = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_tile_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_req = 1'b0;
    settings_used = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: one-cell sprite at the origin, no alpha limiting
    foreach (TILES_DEFAULT[k]) send_tile(TILES_DEFAULT[k]);
    wait_drained();

    // far corner, 3x2 sprite so rows and the sprite wrap, alpha limited to 0xA
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    configure(11'h7FF, 11'h7FF, 11'd3, 11'd2, 1'b1, 4'hA);
    write_reg(CFG_SPARE_LO, 11'h7FF);
    write_reg(CFG_SPARE_HI, 11'h5A5);
    foreach (TILES_LIMITED[k]) send_tile(TILES_LIMITED[k]);
    wait_drained();

    // zero sizes act as one cell; limit 0 blanks everything until mode is off
    configure(11'd0, 11'd0, 11'd0, 11'd0, 1'b1, 4'h0);
    send_tile(32'hFFFF_FFFF);
    send_tile(32'hC0DE_F00D);
    wait_drained();
    write_reg(CFG_ALPHA_EN, 11'd0);
    send_tile(32'hC0DE_F00D);
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      w = pick_cells();
      h = pick_cells();
      en = 1'($urandom_range(0, 1));
      lim = 4'($urandom_range(0, 15));
      if (ph == 1) begin
        w = 11'h7FF;
        h = 11'd256;
      end
      if (ph == 4) en = 1'b0;
      configure(pick_origin(), pick_origin(), w, h, en, lim);
      tx_gaps = (ph != 2 && ph != 4);
      rx_stalls = (ph != 3);
      // hold the receiver off while tiles keep coming, filling the queue
      if (ph == 4) hold_req = 1'b1;
      for (n = 0; n < TILES_PER_PHASE; n++) begin
        word = $urandom();
        r = $urandom_range(0, 99);
        if (r < 12) word[31:28] = 4'h0;
        else if (r < 18) word[15:0] = 16'h0000;
        else if (r < 24) word[15:0] = 16'hFFFF;
        send_tile(word);
      end
      wait_drained();
    end

    $display("Covered %0d tiles (%0d blank), %0d pixel beats checked, %0d register settings",
             model.tiles_seen, model.tiles_blank, model.pixels_seen, settings_used);
    if (model.pending.size() != 0) begin
      $error("%0d pixel beats never arrived", model.pending.size());
      model.errors++;
    end
    if (model.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: fg_bg_tile_sprite_expander.f
+incdir+rtl
rtl/fbte_pkg.sv
rtl/fbte_front.sv
rtl/fbte_queue.sv
rtl/fbte_back.sv
rtl/fg_bg_tile_sprite_expander.sv
test/fg_bg_tile_sprite_expander_tb.sv
